// File: rtl/text_console_cursor_engine_macros.svh
// Assertion macros shared by the text console cursor engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tcce_pkg.sv
// Package with types and constants of the text console cursor engine.
package tcce_pkg;

    localparam int LINE_CELLS_DEF   = 80;
    localparam int SCREEN_CELLS_DEF = 2000;
    localparam int CELL_SPACE       = 16384;
    localparam int VIEW_SPACE       = 32768;

    localparam int CELL_W      = 14;
    localparam int VIEW_W      = 15;
    localparam int CAP_W       = 16;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 1;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    typedef enum logic [1:0] {
        CMD_PUT_CHAR    = 2'd0,
        CMD_SCROLL_UP   = 2'd1,
        CMD_SCROLL_DOWN = 2'd2,
        CMD_CLEAR       = 2'd3
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_CELL  = 1'b0,
        REG_CELL_LIMIT = 1'b1
    } t_reg_idx;

endpackage

// File: rtl/text_console_cursor_engine.sv
// Text console cursor and view engine: cursor, view start and cell writes per command.
//
//  channel   | dir | transfer contents
//  s_axis    | in  | command, char_code, color, line_count
//  m_axis    | out | write_enable, write_address, write_data, cursor_now, view_now,
//            |     | clear_request
//  i_cfg_*   | in  | register write: index 0 base_cell, index 1 cell_limit
//
// Each command goes through the input register, then the output register; one command
// can be accepted every cycle while the output is not stalled and no configuration is
// pending. The cursor and view update is one pass through the logic between the two.
// After reset and during and after each configuration write, s_axis_tready stays low
// while the region end, cap and line columns are recomputed. A stalled output holds
// its transfer, and the input side then holds as well.
module text_console_cursor_engine #(
    parameter int LINE_CELLS   = tcce_pkg::LINE_CELLS_DEF,
    parameter int SCREEN_CELLS = tcce_pkg::SCREEN_CELLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: command[2], char_code[8], color[8], line_count[8], zero pad.
    input  logic [tcce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: write_enable[1], write_address[14], write_data[16],
    // cursor_now[14], view_now[15], clear_request[1], zero pad.
    output logic [tcce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import tcce_pkg::*;

    `include "text_console_cursor_engine_macros.svh"

    localparam int CW      = $clog2(LINE_CELLS + 1);
    localparam int CW1     = CW + 1;
    localparam int SUM_W   = 17;
    localparam int RECIP   = 65536 / LINE_CELLS;
    localparam int SCR_MOD = SCREEN_CELLS % LINE_CELLS;
    localparam int TRC_MOD = VIEW_SPACE % LINE_CELLS;

    // Configuration registers and derived region values.
    logic [CELL_W-1:0] r_base;
    logic [VIEW_W-1:0] r_limit;
    logic [2:0]        r_cfg_busy;
    logic [CAP_W-1:0]  r_cap;
    logic [VIEW_W-1:0] r_end;
    logic [VIEW_W-1:0] r_bq;
    logic [VIEW_W-1:0] r_kq;
    logic [CW-1:0]     r_bcol;
    logic [CW-1:0]     r_kcol;

    logic [CAP_W-1:0]  n_cap;
    logic [31:0]       n_bprod;
    logic [31:0]       n_kprod;
    logic [CAP_W-1:0]  n_brem;
    logic [CAP_W-1:0]  n_krem;

    // Pipeline registers.
    logic              r_in_valid;
    t_cmd              r_in_cmd;
    logic [7:0]        r_in_char;
    logic [7:0]        r_in_color;
    logic [7:0]        r_in_lines;
    logic              r_out_valid;
    logic              r_out_we;
    logic [CELL_W-1:0] r_out_wa;
    logic [15:0]       r_out_wd;
    logic              r_out_clr;

    // Cursor and view state with their columns within a line.
    logic [CELL_W-1:0] r_cursor;
    logic [VIEW_W-1:0] r_view;
    logic [CW-1:0]     r_ccol;
    logic [CW-1:0]     r_vcol;

    logic [CELL_W-1:0] n_cursor;
    logic [VIEW_W-1:0] n_view;
    logic [CW-1:0]     n_ccol;
    logic [CW-1:0]     n_vcol;
    logic              n_we;
    logic [CELL_W-1:0] n_wa;
    logic [15:0]       n_wd;
    logic              n_clr;

    logic              cfg_idle;
    logic              advance;
    logic              in_xfer;

    function automatic logic [CW-1:0] col_sub(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW1-1:0] t;
        if (a >= b) begin
            t = CW1'(a) - CW1'(b);
        end else begin
            t = CW1'(a) + CW1'(LINE_CELLS) - CW1'(b);
        end
        return t[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] col_pad(input logic [CW-1:0] d);
        logic [CW-1:0] p;
        if (d == '0) begin
            p = '0;
        end else begin
            p = CW'(LINE_CELLS) - d;
        end
        return p;
    endfunction

    // Handshake control.
    assign cfg_idle      = !i_cfg_we && (r_cfg_busy == '0);
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = cfg_idle && (!r_in_valid || advance);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_clr, r_view, r_cursor, r_out_wd, r_out_wa,
                            r_out_we};

    // Region values: cap and end, then the line column of base and truncated cap.
    always_comb begin
        n_cap   = CAP_W'(r_base) + CAP_W'(r_limit);
        n_bprod = 32'(r_base) * 32'(RECIP);
        n_kprod = 32'(r_cap[VIEW_W-1:0]) * 32'(RECIP);
        n_brem  = CAP_W'(r_base) - CAP_W'(32'(r_bq) * 32'(LINE_CELLS));
        n_krem  = CAP_W'(r_cap[VIEW_W-1:0]) - CAP_W'(32'(r_kq) * 32'(LINE_CELLS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_limit    <= VIEW_W'(CELL_SPACE);
            r_cfg_busy <= '1;
        end else begin
            r_cfg_busy <= {r_cfg_busy[1:0], i_cfg_we};
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_BASE_CELL:  r_base  <= i_cfg_data[CELL_W-1:0];
                    REG_CELL_LIMIT: r_limit <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap  <= n_cap;
        r_end  <= (n_cap > CAP_W'(CELL_SPACE)) ? VIEW_W'(CELL_SPACE) : n_cap[VIEW_W-1:0];
        r_bq   <= n_bprod[30:16];
        r_kq   <= n_kprod[30:16];
        r_bcol <= (n_brem >= CAP_W'(LINE_CELLS)) ? CW'(n_brem - CAP_W'(LINE_CELLS))
                                                 : CW'(n_brem);
        r_kcol <= (n_krem >= CAP_W'(LINE_CELLS)) ? CW'(n_krem - CAP_W'(LINE_CELLS))
                                                 : CW'(n_krem);
    end

    // One command: cursor move and cell write with the view following, a scroll, or a clear home.
    always_comb begin
        logic [CELL_W-1:0] c1;
        logic [CW-1:0]     col1;
        logic [CW-1:0]     pad;
        logic [SUM_W-1:0]  vd;
        logic [SUM_W-1:0]  lines;
        logic [SUM_W-1:0]  vs;

        c1       = r_cursor;
        col1     = r_ccol;
        pad      = '0;
        vd       = '0;
        lines    = SUM_W'(r_in_lines) * SUM_W'(LINE_CELLS);
        vs       = '0;
        n_cursor = r_cursor;
        n_view   = r_view;
        n_ccol   = r_ccol;
        n_vcol   = r_vcol;
        n_we     = 1'b0;
        n_wa     = '0;
        n_wd     = '0;
        n_clr    = 1'b0;

        unique case (r_in_cmd)
            CMD_PUT_CHAR: begin
                priority if (r_in_char == CH_NEWLINE) begin
                    if (SUM_W'(r_cursor) + SUM_W'(LINE_CELLS) < SUM_W'(r_end)) begin
                        c1   = CELL_W'(SUM_W'(r_cursor) + SUM_W'(LINE_CELLS)
                                       - SUM_W'(r_ccol));
                        col1 = '0;
                    end
                end else if (r_in_char == CH_BACKSPACE) begin
                    if (r_cursor > r_base) begin
                        c1   = r_cursor - CELL_W'(1);
                        col1 = (r_ccol == '0) ? CW'(LINE_CELLS - 1) : r_ccol - CW'(1);
                        n_we = 1'b1;
                        n_wa = c1;
                        n_wd = {r_in_color, CH_BLANK};
                    end
                end else if (r_in_char != CH_NUL) begin
                    if (SUM_W'(r_cursor) + SUM_W'(1) < SUM_W'(r_end)) begin
                        c1   = r_cursor + CELL_W'(1);
                        col1 = (r_ccol == CW'(LINE_CELLS - 1)) ? '0 : r_ccol + CW'(1);
                        n_we = 1'b1;
                        n_wa = r_cursor;
                        n_wd = {r_in_color, r_in_char};
                    end
                end else begin
                    c1 = r_cursor;
                end
                n_cursor = c1;
                n_ccol   = col1;
                if (VIEW_W'(c1) < r_view) begin
                    pad = col_pad(col_sub(r_vcol, col1));
                    if (SUM_W'(c1) >= SUM_W'(r_base) + SUM_W'(pad)) begin
                        n_view = VIEW_W'(SUM_W'(c1) - SUM_W'(pad));
                    end else begin
                        n_view = VIEW_W'(r_base);
                        n_vcol = r_bcol;
                    end
                end else if (SUM_W'(c1) > SUM_W'(r_view) + SUM_W'(SCREEN_CELLS)) begin
                    pad = col_pad(col_sub(col_sub(col1, r_vcol), CW'(SCR_MOD)));
                    vd  = SUM_W'(c1) + SUM_W'(pad) - SUM_W'(SCREEN_CELLS);
                    if (vd < SUM_W'(r_cap)) begin
                        n_view = VIEW_W'(vd);
                    end else begin
                        n_view = r_cap[VIEW_W-1:0];
                        n_vcol = r_kcol;
                    end
                end
            end
            CMD_SCROLL_UP: begin
                if (SUM_W'(r_view) >= SUM_W'(r_base) + lines) begin
                    n_view = VIEW_W'(SUM_W'(r_view) - lines);
                end else begin
                    n_view = VIEW_W'(r_base);
                    n_vcol = r_bcol;
                end
            end
            CMD_SCROLL_DOWN: begin
                vs = SUM_W'(r_view) + lines;
                if (vs < SUM_W'(r_cap)) begin
                    n_view = vs[VIEW_W-1:0];
                    if (vs[VIEW_W]) begin
                        n_vcol = col_sub(r_vcol, CW'(TRC_MOD));
                    end
                end else begin
                    n_view = r_cap[VIEW_W-1:0];
                    n_vcol = r_kcol;
                end
            end
            CMD_CLEAR: begin
                n_cursor = r_base;
                n_view   = VIEW_W'(r_base);
                n_ccol   = r_bcol;
                n_vcol   = r_bcol;
                n_clr    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cursor    <= '0;
            r_view      <= '0;
            r_ccol      <= '0;
            r_vcol      <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && advance) begin
                r_cursor <= n_cursor;
                r_view   <= n_view;
                r_ccol   <= n_ccol;
                r_vcol   <= n_vcol;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd   <= t_cmd'(s_axis_tdata[1:0]);
            r_in_char  <= s_axis_tdata[9:2];
            r_in_color <= s_axis_tdata[17:10];
            r_in_lines <= s_axis_tdata[25:18];
        end
        if (r_in_valid && advance) begin
            r_out_we  <= n_we;
            r_out_wa  <= n_wa;
            r_out_wd  <= n_wd;
            r_out_clr <= n_clr;
        end
    end

    `TCCE_ASSERT_IMP(a_col_range, i_clk, i_rst_n, 1'b1,
        (r_ccol < CW'(LINE_CELLS)) && (r_vcol < CW'(LINE_CELLS)),
        "cursor or view column out of range")
    `TCCE_ASSERT_IMP(a_write_at_cursor, i_clk, i_rst_n, r_out_valid && r_out_we,
        (r_out_wa == r_cursor) || (r_out_wa + CELL_W'(1) == r_cursor),
        "cell write not adjacent to the new cursor")
    `TCCE_ASSERT_IMP(a_clear_home, i_clk, i_rst_n, r_out_valid && r_out_clr,
        (VIEW_W'(r_cursor) == r_view) && !r_out_we,
        "clear did not home cursor and view")
    `TCCE_ASSERT_NXT(a_cfg_hold, i_clk, i_rst_n, i_cfg_we, !s_axis_tready,
        "input taken while region values are recomputed")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text console cursor engine with directed and random streams.
module testbench;
    import tcce_pkg::*;

    localparam int ITEMS_PER_PHASE = 125;
    localparam int PHASES          = 16;

    typedef struct {
        logic        write_enable;
        logic [13:0] write_address;
        logic [15:0] write_data;
        logic [13:0] cursor_now;
        logic [14:0] view_now;
        logic        clear_request;
    } t_console_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int base_cell   = 0;
    int cell_limit  = CELL_SPACE;
    int cursor_cell = 0;
    int view_start  = 0;

    t_console_result pending_results[$];
    int              error_count = 0;
    bit              no_idle     = 1'b0;
    int              stall_left  = 0;

    text_console_cursor_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic void move_view_up(int lines);
        int span;
        span = lines * LINE_CELLS_DEF;
        if (view_start >= base_cell + span) begin
            view_start = view_start - span;
        end else begin
            view_start = base_cell;
        end
    endfunction

    function automatic void move_view_down(int lines);
        int target;
        int cap;
        target = view_start + lines * LINE_CELLS_DEF;
        cap    = base_cell + cell_limit;
        view_start = (target < cap) ? target : cap;
    endfunction

    function automatic void bring_cursor_into_view();
        int gap;
        if (cursor_cell < view_start) begin
            gap = view_start - cursor_cell;
            move_view_up((gap + LINE_CELLS_DEF - 1) / LINE_CELLS_DEF);
        end else if (cursor_cell - view_start > SCREEN_CELLS_DEF) begin
            gap = cursor_cell - view_start - SCREEN_CELLS_DEF;
            move_view_down((gap + LINE_CELLS_DEF - 1) / LINE_CELLS_DEF);
        end
    endfunction

    function automatic t_console_result apply_command(t_cmd cmd, logic [7:0] ch,
                                                      logic [7:0] col, logic [7:0] lines);
        t_console_result res;
        int              region_end;
        res = '{default: '0};
        case (cmd)
            CMD_PUT_CHAR: begin
                region_end = base_cell + cell_limit;
                if (region_end > CELL_SPACE) begin
                    region_end = CELL_SPACE;
                end
                if (ch == CH_NEWLINE) begin
                    if (cursor_cell < region_end - LINE_CELLS_DEF) begin
                        cursor_cell = cursor_cell + LINE_CELLS_DEF
                                      - cursor_cell % LINE_CELLS_DEF;
                    end
                end else if (ch == CH_BACKSPACE) begin
                    if (cursor_cell > base_cell) begin
                        cursor_cell--;
                        res.write_enable  = 1'b1;
                        res.write_address = cursor_cell[13:0];
                        res.write_data    = {col, CH_BLANK};
                    end
                end else if (ch != CH_NUL) begin
                    if (cursor_cell < region_end - 1) begin
                        res.write_enable  = 1'b1;
                        res.write_address = cursor_cell[13:0];
                        res.write_data    = {col, ch};
                        cursor_cell++;
                    end
                end
                bring_cursor_into_view();
            end
            CMD_SCROLL_UP: begin
                move_view_up(int'(lines));
            end
            CMD_SCROLL_DOWN: begin
                move_view_down(int'(lines));
            end
            CMD_CLEAR: begin
                cursor_cell = base_cell;
                view_start  = base_cell;
                res.clear_request = 1'b1;
            end
        endcase
        cursor_cell &= 'h3FFF;
        view_start  &= 'h7FFF;
        res.cursor_now = cursor_cell[13:0];
        res.view_now   = view_start[14:0];
        return res;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    task automatic check_result(logic [OUT_TDATA_W-1:0] word);
        t_console_result want;
        if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: transfer with nothing expected, actual %h", $time, word);
            return;
        end
        want = pending_results.pop_front();
        check_field("write_enable", 16'(want.write_enable), 16'(word[0]));
        check_field("write_address", 16'(want.write_address), 16'(word[14:1]));
        check_field("write_data", want.write_data, word[30:15]);
        check_field("cursor_now", 16'(want.cursor_now), 16'(word[44:31]));
        check_field("view_now", 16'(want.view_now), 16'(word[59:45]));
        check_field("clear_request", 16'(want.clear_request), 16'(word[60]));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                stall_left = draw_wait();
                m_axis_tready <= (stall_left == 0);
            end else if (!m_axis_tready) begin
                stall_left--;
                if (stall_left <= 0) begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_item(t_cmd cmd, logic [7:0] ch, logic [7:0] col, logic [7:0] lines);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, lines, col, ch, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_command(cmd, ch, col, lines));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_BASE_CELL) begin
            base_cell = value & 'h3FFF;
        end else begin
            cell_limit = value & 'h7FFF;
        end
    endtask

    task automatic set_region(int first_cell, int cells);
        write_reg(REG_BASE_CELL, first_cell);
        write_reg(REG_CELL_LIMIT, cells);
    endtask

    task automatic test_reset_region();
        send_item(CMD_PUT_CHAR, 8'h41, 8'hFF, 8'h00);
        send_item(CMD_PUT_CHAR, 8'hFF, 8'h00, 8'hFF);
        send_item(CMD_PUT_CHAR, 8'h80, 8'h5A, 8'h00);
        send_item(CMD_PUT_CHAR, CH_NUL, 8'hFF, 8'h00);
        send_item(CMD_PUT_CHAR, CH_NEWLINE, 8'h07, 8'h00);
        send_item(CMD_PUT_CHAR, CH_BACKSPACE, 8'h07, 8'h00);
        send_item(CMD_SCROLL_DOWN, 8'h00, 8'h00, 8'hFF);
        send_item(CMD_PUT_CHAR, 8'h7A, 8'h1E, 8'h00);
        send_item(CMD_SCROLL_UP, 8'h00, 8'h00, 8'h00);
        send_item(CMD_SCROLL_UP, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_SCROLL_DOWN, 8'hFF, 8'hFF, 8'h00);
        send_item(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_PUT_CHAR, CH_BACKSPACE, 8'h70, 8'h00);
    endtask

    task automatic test_region_edges();
        // The cursor is left below a raised base, with the view pushed past it.
        set_region(200, CELL_SPACE);
        send_item(CMD_SCROLL_DOWN, 8'h00, 8'h00, 8'd5);
        send_item(CMD_PUT_CHAR, 8'h42, 8'h0F, 8'h00);
        send_item(CMD_PUT_CHAR, CH_BACKSPACE, 8'h0F, 8'h00);
        set_region(16383, 1);
        send_item(CMD_CLEAR, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PUT_CHAR, 8'h43, 8'h0F, 8'h00);
        send_item(CMD_PUT_CHAR, CH_NEWLINE, 8'h0F, 8'h00);
        send_item(CMD_SCROLL_DOWN, 8'h00, 8'h00, 8'hFF);
        send_item(CMD_SCROLL_UP, 8'h00, 8'h00, 8'd1);
        set_region(16300, CELL_SPACE);
        send_item(CMD_CLEAR, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PUT_CHAR, CH_NEWLINE, 8'h0F, 8'h00);
        send_item(CMD_PUT_CHAR, CH_NEWLINE, 8'h0F, 8'h00);
        set_region(0, 79);
        send_item(CMD_CLEAR, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PUT_CHAR, CH_NEWLINE, 8'h0F, 8'h00);
        send_item(CMD_PUT_CHAR, 8'h44, 8'hA5, 8'h00);
    endtask

    task automatic send_random_item();
        int         pick;
        logic [7:0] ch;
        logic [7:0] lines;
        pick  = $urandom_range(0, 99);
        ch    = 8'($urandom_range(0, 255));
        lines = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 30));
        if (pick < 72) begin
            case ($urandom_range(0, 9))
                0, 1: ch = CH_NEWLINE;
                2: ch = CH_BACKSPACE;
                3: if ($urandom_range(0, 3) == 0) ch = CH_NUL;
                default: ;
            endcase
            send_item(CMD_PUT_CHAR, ch, 8'($urandom_range(0, 255)), lines);
        end else if (pick < 86) begin
            send_item(CMD_SCROLL_UP, ch, 8'($urandom_range(0, 255)), lines);
        end else if (pick < 98) begin
            send_item(CMD_SCROLL_DOWN, ch, 8'($urandom_range(0, 255)), lines);
        end else begin
            send_item(CMD_CLEAR, ch, 8'($urandom_range(0, 255)), lines);
        end
    endtask

    task automatic test_random_phases();
        int first_cell;
        int cells;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin first_cell = 0;     cells = CELL_SPACE; end
                1: begin first_cell = 16383; cells = CELL_SPACE; end
                2: begin first_cell = 0;     cells = 1;          end
                3: begin first_cell = 16000; cells = CELL_SPACE; end
                default: begin
                    first_cell = $urandom_range(0, 16383);
                    case ($urandom_range(0, 3))
                        0: cells = $urandom_range(1, 79);
                        1: cells = $urandom_range(80, 600);
                        2: cells = $urandom_range(2000, 4500);
                        default: cells = $urandom_range(1, CELL_SPACE);
                    endcase
                end
            endcase
            set_region(first_cell, cells);
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1) begin
                send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end
            repeat (ITEMS_PER_PHASE) send_random_item();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_region();
        test_region_edges();
        test_random_phases();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("text_console_cursor_engine: match");
        end else begin
            $display("text_console_cursor_engine: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("text_console_cursor_engine: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcce_pkg.sv
rtl/text_console_cursor_engine.sv
tb/testbench.sv
